/* design/dorq_pkg.sv */
// Package: constants, entry layout and sequencer states for the redraw queue.
package dorq_pkg;
   localparam int DEPTH_DEFAULT = 16;
   localparam int OWNER_W = 8;
   localparam int AREA_W = 48;
   localparam int TIME_W = 48;
   localparam int ENTRY_W = OWNER_W + AREA_W + TIME_W;
   localparam int REQ_DATA_W = 104;
   localparam int RSP_DATA_W = 112;

   localparam logic CMD_SCHEDULE = 1'b0;
   localparam logic CMD_EXPIRE = 1'b1;
   localparam logic KIND_STATUS = 1'b0;
   localparam logic KIND_REDRAW = 1'b1;

   typedef struct packed {
      logic [OWNER_W-1:0] owner;
      logic [AREA_W-1:0]  area;
      logic [TIME_W-1:0]  due;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_SCAN,
      ST_INSERT,
      ST_HEAD,
      ST_STATUS,
      ST_OUT
   } state_type;
endpackage

/* design/dorq_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module dorq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

/* design/deadline_ordered_redraw_queue_unit.sv */
// Top level: deadline-sorted redraw queue held in a ping-pong pair of RAMs.
//
// Input beats on req_ carry schedule or expire commands; result beats on
// rsp_ carry redraw results (one per expired entry) and always end with one
// status beat flagged by rsp_tlast. Items are processed one at a time.
// Each item makes a compacting pass over the occupied entries: the live
// queue is read from one RAM bank, one entry per ST_READ/ST_SCAN pair, and
// the surviving entries, with a new entry merged at its sorted place, are
// written to the other bank; the banks then swap roles, except when a
// schedule overflows a full queue and the old bank is kept.
// Expired entries leave as redraw beats during the pass; while rsp_tready is
// low a redraw beat that cannot yet enter the result register makes the
// pass reread its entry, and a waiting status beat holds the sequencer in
// ST_OUT. The result register holds each beat until taken. Reset empties
// the queue at once through the fill count; the RAM contents need no
// clearing. req_tready is high only while no item is in progress.
module deadline_ordered_redraw_queue_unit #(
   parameter int QUEUE_DEPTH = dorq_pkg::DEPTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // owner_id[7:0], area_x, area_y, area_width, area_height, time_value
   input  logic [dorq_pkg::REQ_DATA_W-1:0] req_tdata,
   // command
   input  logic                            req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // out_owner, out_x, out_y, out_width, out_height, next_due,
   // next_due_valid, queue_overflow, zero fill
   output logic [dorq_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // result_kind
   output logic                            rsp_tuser,
   output logic                            rsp_tlast
);
   import dorq_pkg::*;

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   state_type state_ff, state_in;
   logic bank_ff, bank_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] rd_idx_ff, rd_idx_in;
   logic [CW-1:0] wr_idx_ff, wr_idx_in;
   logic cmd_ff, cmd_in;
   entry_type new_ff, new_in;
   logic placed_ff, placed_in;
   logic removed_ff, removed_in;
   logic ovf_ff, ovf_in;
   logic expiring_ff, expiring_in;

   logic out_valid_ff, out_valid_in;
   logic [RSP_DATA_W-1:0] out_data_ff, out_data_in;
   logic out_kind_ff, out_kind_in;
   logic out_last_ff, out_last_in;

   logic wr_en [2];
   logic [AW-1:0] wr_addr;
   entry_type wr_data;
   logic [AW-1:0] rd_addr;
   entry_type rd_data [2];
   entry_type cur;
   logic out_free;

   for (genvar b = 0; b < 2; b++) begin : g_bank
      dorq_ram #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_ram (
         .clock  (clock),
         .wr_en  (wr_en[b]),
         .wr_addr(wr_addr),
         .wr_data(wr_data),
         .rd_addr(rd_addr),
         .rd_data(rd_data[b])
      );
   end

   assign cur = bank_ff ? rd_data[1] : rd_data[0];
   assign out_free = !out_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         bank_ff <= 1'b0;
         count_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         bank_ff <= bank_in;
         count_ff <= count_in;
         out_valid_ff <= out_valid_in;
      end
      rd_idx_ff <= rd_idx_in;
      wr_idx_ff <= wr_idx_in;
      cmd_ff <= cmd_in;
      new_ff <= new_in;
      placed_ff <= placed_in;
      removed_ff <= removed_in;
      ovf_ff <= ovf_in;
      expiring_ff <= expiring_in;
      out_data_ff <= out_data_in;
      out_kind_ff <= out_kind_in;
      out_last_ff <= out_last_in;
   end

   always_comb begin
      state_in = state_ff;
      bank_in = bank_ff;
      count_in = count_ff;
      rd_idx_in = rd_idx_ff;
      wr_idx_in = wr_idx_ff;
      cmd_in = cmd_ff;
      new_in = new_ff;
      placed_in = placed_ff;
      removed_in = removed_ff;
      ovf_in = ovf_ff;
      expiring_in = expiring_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_data_in = out_data_ff;
      out_kind_in = out_kind_ff;
      out_last_in = out_last_ff;
      wr_en[0] = 1'b0;
      wr_en[1] = 1'b0;
      wr_addr = wr_idx_ff[AW-1:0];
      wr_data = cur;
      rd_addr = rd_idx_ff[AW-1:0];
      req_tready = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd_in = req_tuser;
               new_in.owner = req_tdata[7:0];
               new_in.area = req_tdata[55:8];
               new_in.due = req_tdata[103:56];
               placed_in = 1'b0;
               removed_in = 1'b0;
               ovf_in = 1'b0;
               expiring_in = 1'b1;
               rd_idx_in = '0;
               wr_idx_in = '0;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            // issue read of the entry at rd_idx
            if (rd_idx_ff < count_ff) begin
               rd_addr = rd_idx_ff[AW-1:0];
               state_in = ST_SCAN;
            end else begin
               state_in = ST_INSERT;
            end
         end
         ST_SCAN: begin
            if (cmd_ff == CMD_SCHEDULE) begin
               if (cur.owner == new_ff.owner) begin
                  removed_in = 1'b1;
                  rd_idx_in = rd_idx_ff + 1'b1;
                  state_in = ST_READ;
               end else if (!placed_ff && cur.due > new_ff.due) begin
                  // merge new entry ahead of this one, reread this one
                  wr_en[!bank_ff] = 1'b1;
                  wr_data = new_ff;
                  placed_in = 1'b1;
                  wr_idx_in = wr_idx_ff + 1'b1;
                  state_in = ST_READ;
               end else begin
                  wr_en[!bank_ff] = 1'b1;
                  wr_idx_in = wr_idx_ff + 1'b1;
                  rd_idx_in = rd_idx_ff + 1'b1;
                  state_in = ST_READ;
               end
            end else if (expiring_ff && cur.due <= new_ff.due) begin
               if (out_free) begin
                  out_valid_in = 1'b1;
                  out_kind_in = KIND_REDRAW;
                  out_last_in = 1'b0;
                  out_data_in = '0;
                  out_data_in[55:0] = {cur.area, cur.owner};
                  rd_idx_in = rd_idx_ff + 1'b1;
                  state_in = ST_READ;
               end else begin
                  state_in = ST_READ;
               end
            end else begin
               expiring_in = 1'b0;
               wr_en[!bank_ff] = 1'b1;
               wr_idx_in = wr_idx_ff + 1'b1;
               rd_idx_in = rd_idx_ff + 1'b1;
               state_in = ST_READ;
            end
         end
         ST_INSERT: begin
            if (cmd_ff == CMD_SCHEDULE) begin
               if (!removed_ff && count_ff == CW'(QUEUE_DEPTH)) begin
                  ovf_in = 1'b1;
                  wr_idx_in = count_ff;
                  bank_in = !bank_ff;
               end else if (!placed_ff) begin
                  wr_en[!bank_ff] = 1'b1;
                  wr_data = new_ff;
                  wr_idx_in = wr_idx_ff + 1'b1;
               end
            end
            state_in = ST_HEAD;
         end
         ST_HEAD: begin
            // overflow keeps the old bank: flip twice means unchanged
            bank_in = !bank_ff;
            count_in = wr_idx_ff;
            state_in = ST_STATUS;
         end
         ST_STATUS: begin
            rd_addr = '0;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            rd_addr = '0;
            if (out_free) begin
               out_valid_in = 1'b1;
               out_kind_in = KIND_STATUS;
               out_last_in = 1'b1;
               out_data_in = '0;
               if (count_ff != '0) begin
                  out_data_in[56+:TIME_W] = cur.due;
                  out_data_in[104] = 1'b1;
               end
               out_data_in[105] = ovf_ff;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = out_data_ff;
   assign rsp_tuser = out_kind_ff;
   assign rsp_tlast = out_last_ff;

   property p_no_accept_busy;
      @(posedge clock) disable iff (reset)
         (state_ff != ST_IDLE) |-> !req_tready;
   endproperty
   assert property (p_no_accept_busy) else $error("input taken while busy");

   property p_count_bound;
      @(posedge clock) disable iff (reset) count_ff <= CW'(QUEUE_DEPTH);
   endproperty
   assert property (p_count_bound) else $error("fill count beyond depth");

   property p_last_status;
      @(posedge clock) disable iff (reset)
         rsp_tvalid |-> (rsp_tlast == (rsp_tuser == KIND_STATUS));
   endproperty
   assert property (p_last_status) else $error("tlast not on status beat");
endmodule

/* sim/tb_deadline_ordered_redraw_queue_unit.sv */
// Testbench: random and directed schedule/expire traffic checked against a sorted-queue predictor.
`timescale 1ns / 1ps

class redraw_scoreboard;
   typedef struct {
      logic [7:0]  owner;
      logic [47:0] area;
      logic [47:0] due;
   } slot_type;

   slot_type pending[$];
   logic [111:0] want_data[$];
   logic         want_kind[$];
   logic         want_last[$];
   int           depth;
   int           errors;

   function new(int d);
      depth = d;
      errors = 0;
   endfunction

   function void push_beat(logic kind, logic [111:0] data, logic lst);
      want_kind.push_back(kind);
      want_data.push_back(data);
      want_last.push_back(lst);
   endfunction

   function void note_item(logic cmd, logic [103:0] data);
      logic [7:0]  owner;
      logic [47:0] area;
      logic [47:0] t;
      logic        ovf;
      int          pos;
      slot_type    s;
      owner = data[7:0];
      area = data[55:8];
      t = data[103:56];
      ovf = 1'b0;
      if (cmd == dorq_pkg::CMD_SCHEDULE) begin
         for (int i = pending.size() - 1; i >= 0; i--)
            if (pending[i].owner == owner) pending.delete(i);
         if (pending.size() >= depth) begin
            ovf = 1'b1;
         end else begin
            pos = 0;
            while (pos < pending.size() && pending[pos].due <= t) pos++;
            s.owner = owner;
            s.area = area;
            s.due = t;
            pending.insert(pos, s);
         end
      end else begin
         while (pending.size() > 0 && pending[0].due <= t) begin
            push_beat(dorq_pkg::KIND_REDRAW,
                      {56'd0, pending[0].area, pending[0].owner}, 1'b0);
            void'(pending.pop_front());
         end
      end
      if (pending.size() > 0)
         push_beat(dorq_pkg::KIND_STATUS, {6'd0, ovf, 1'b1, pending[0].due, 56'd0}, 1'b1);
      else
         push_beat(dorq_pkg::KIND_STATUS, {6'd0, ovf, 1'b0, 48'd0, 56'd0}, 1'b1);
   endfunction

   function void check_beat(logic kind, logic [111:0] data, logic lst);
      if (want_data.size() == 0) begin
         errors++;
         if (errors <= 10) $display("unexpected beat kind=%0d data=%h", kind, data);
         return;
      end
      if (kind !== want_kind[0] || data !== want_data[0] || lst !== want_last[0]) begin
         errors++;
         if (errors <= 10)
            $display("mismatch: expected kind=%0d last=%0d data=%h, got kind=%0d last=%0d data=%h",
                     want_kind[0], want_last[0], want_data[0], kind, lst, data);
      end
      void'(want_kind.pop_front());
      void'(want_data.pop_front());
      void'(want_last.pop_front());
   endfunction
endclass

module tb_deadline_ordered_redraw_queue_unit;
   import dorq_pkg::*;

   localparam int DEPTH = 16;
   localparam int CYCLE_LIMIT = 200000;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  rsp_tlast;

   redraw_scoreboard board;
   int  cycles;
   bit  quiet_idle;
   bit  hold_rsp;

   deadline_ordered_redraw_queue_unit #(.QUEUE_DEPTH(DEPTH)) DUT (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) board.note_item(req_tuser, req_tdata);
      if (!reset && rsp_tvalid && rsp_tready) board.check_beat(rsp_tuser, rsp_tdata, rsp_tlast);
   end

   always @(negedge clock) begin
      if (reset || hold_rsp) rsp_tready <= 1'b0;
      else rsp_tready <= quiet_idle ? 1'b1 : ($urandom_range(99) >= 11);
   end

   task automatic send_beat(logic cmd, logic [103:0] data);
      while (!quiet_idle && $urandom_range(99) < 11) @(negedge clock);
      req_tvalid = 1'b1;
      req_tuser = cmd;
      req_tdata = data;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   task automatic schedule(logic [7:0] owner, logic [47:0] area, logic [47:0] due);
      send_beat(CMD_SCHEDULE, {due, area, owner});
   endtask

   task automatic expire(logic [47:0] now);
      send_beat(CMD_EXPIRE, {now, 48'({$urandom, $urandom}), 8'($urandom)});
   endtask

   task automatic drain();
      while (board.want_data.size() > 0) @(negedge clock);
   endtask

   function automatic logic [47:0] rand_area();
      return {16'($urandom), $urandom};
   endfunction

   function automatic logic [47:0] rand_due();
      case ($urandom_range(3))
         0: return 48'($urandom_range(63));
         1: return {16'($urandom), $urandom};
         2: return 48'hFFFF_FFFF_FFFF - $urandom_range(7);
         default: return 48'($urandom_range(4000));
      endcase
   endfunction

   initial begin
      board = new(DEPTH);
      cycles = 0;
      quiet_idle = 1'b0;
      hold_rsp = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      expire(48'd0);
      schedule(8'd0, 48'd0, 48'd0);
      schedule(8'hFF, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF);
      schedule(8'd5, rand_area(), 48'd100);
      schedule(8'd6, rand_area(), 48'd100);
      schedule(8'd5, rand_area(), 48'd50);
      expire(48'd99);
      for (int i = 0; i < 17; i++) schedule(8'(i + 20), rand_area(), 48'(200 - i));
      schedule(8'd25, rand_area(), 48'd10);
      expire(48'hFFFF_FFFF_FFFF);
      expire(48'd5);
      drain();

      hold_rsp = 1'b1;
      fork
         begin
            repeat (400) @(negedge clock);
            hold_rsp = 1'b0;
         end
         for (int i = 0; i < 12; i++) begin
            schedule(8'($urandom_range(15)), rand_area(), rand_due());
            if (i % 4 == 3) expire(rand_due());
         end
      join
      drain();

      for (int n = 0; n < 260; n++) begin
         quiet_idle = (n >= 120 && n < 170);
         if (n == 200) drain();
         if ($urandom_range(99) < 70)
            schedule(8'($urandom_range(n % 50 < 25 ? 23 : 255)), rand_area(), rand_due());
         else
            expire(rand_due());
      end
      drain();
      repeat (50) @(posedge clock);
      if (board.errors == 0 && board.want_data.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule

/* deadline_ordered_redraw_queue_unit.f */
design/dorq_pkg.sv
design/dorq_ram.sv
design/deadline_ordered_redraw_queue_unit.sv
sim/tb_deadline_ordered_redraw_queue_unit.sv
